// ===== hdl/sfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfrs_pkg
// Shared types, constants and codes of the sbus frame receiver and scaler.
// ----------------------------------------------------------------------------
package sfrs_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES  = 25;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned BYTE_W       = 8;
  localparam logic [7:0]  HEADER_BYTE  = 8'h0F;

  // channel unpacking
  localparam int unsigned OUT_CHANNELS = 10;
  localparam int unsigned CH_W         = 4;
  localparam int unsigned RAW_W        = 11;
  localparam int unsigned CH_BITS      = RAW_W * OUT_CHANNELS;

  // counters
  localparam int unsigned GAP_W        = 12;
  localparam int unsigned FCNT_W       = 8;

  // scaling datapath
  localparam int unsigned VAL_W        = 12;
  localparam int unsigned PROD_W       = 24;
  localparam int unsigned NUM_W        = 25;
  localparam int unsigned MAG_W        = 24;
  localparam int unsigned OFFK_W       = 22;
  localparam int unsigned QUOT_W       = 14;
  // floor(n / 1000) == (n * DIV_RECIP) >> DIV_SHIFT for every n below 2**24
  localparam int unsigned DIV_SHIFT    = 34;
  localparam int unsigned RECIP_W      = 25;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd17179870;
  localparam int unsigned DPROD_W      = MAG_W + RECIP_W;

  // job queue between front and back
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = 1;
  localparam int unsigned QCNT_W       = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 12;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_CONVERT = 2'd2,
    KIND_DETECT  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_LIMIT     = 3'd0,
    CFG_MIN_FRAMES    = 3'd1,
    CFG_GAIN_MILLI    = 3'd2,
    CFG_CENTER        = 3'd3,
    CFG_OUTPUT_OFFSET = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] gap_limit;
    logic [7:0]  min_frames;
    logic [10:0] gain_milli;
    logic [10:0] center;
    logic [11:0] output_offset;
  } cfg_t;

  // one convert event handed from front to back
  typedef struct packed {
    logic               lost;
    logic               failsafe;
    logic [CH_BITS-1:0] raw;
  } job_t;

  // per-result tag traveling down the scaler pipeline
  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            lost;
    logic            failsafe;
    logic            last;
  } meta_t;

endpackage

// ===== hdl/sfrs_queue.sv =====
// ----------------------------------------------------------------------------
// sfrs_queue
// Two-entry queue of convert jobs between frame front end and scaler.
// ----------------------------------------------------------------------------
module sfrs_queue
  import sfrs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output job_t pop_data_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign avail_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hdl/sfrs_front.sv =====
// ----------------------------------------------------------------------------
// sfrs_front
// Accepts bytes, ticks and events; assembles frames and issues convert jobs.
// ----------------------------------------------------------------------------
module sfrs_front
  import sfrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_kind_i,
  input  logic [BYTE_W-1:0] in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output job_t              push_data_o
);

  logic [BYTE_W-1:0]             asm_q [FRAME_BYTES];
  logic [CH_BITS-1:0]            latched_q;
  logic [CNT_W-1:0]              byte_cnt_q;
  logic [GAP_W-1:0]              gap_q;
  logic                          seen_q;
  logic [FCNT_W-1:0]             fcnt_q;
  logic                          failsafe_q;

  logic                          accept;
  kind_e                         kind;
  logic                          is_byte;
  logic [CNT_W-1:0]              cnt_base;
  logic [CNT_W-1:0]              wr_idx;
  logic [CNT_W-1:0]              cnt_next;
  logic                          complete;
  logic [FRAME_BYTES*BYTE_W-1:0] frame_next;
  logic                          lost;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = kind_e'(in_kind_i);
  assign is_byte    = accept && (kind == KIND_BYTE);

  // restart checks: line gap, then header or overrun
  always_comb begin
    cnt_base = (seen_q && (gap_q > cfg_i.gap_limit)) ? '0 : byte_cnt_q;
    if ((in_data_i == HEADER_BYTE) || (cnt_base >= CNT_W'(FRAME_BYTES))) begin
      wr_idx = '0;
    end else begin
      wr_idx = cnt_base;
    end
    cnt_next = wr_idx + 1'b1;
    complete = (cnt_next == CNT_W'(FRAME_BYTES));
  end

  // buffer contents after the current byte lands
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_next[i*BYTE_W +: BYTE_W] = (wr_idx == CNT_W'(i)) ? in_data_i : asm_q[i];
    end
  end

  assign lost = (fcnt_q < cfg_i.min_frames);

  // convert job toward the scaler
  assign push_o               = accept && (kind == KIND_CONVERT);
  assign push_data_o.lost     = lost;
  assign push_data_o.failsafe = failsafe_q || lost;
  assign push_data_o.raw      = latched_q;

  // assembly buffer, no reset
  always_ff @(posedge clk_i) begin
    if (is_byte) begin
      asm_q[wr_idx] <= in_data_i;
    end
  end

  // frame state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q  <= '0;
      byte_cnt_q <= '0;
      gap_q      <= '0;
      seen_q     <= 1'b0;
      fcnt_q     <= '0;
      failsafe_q <= 1'b0;
    end else if (accept) begin
      case (kind)
        KIND_BYTE: begin
          byte_cnt_q <= cnt_next;
          gap_q      <= '0;
          seen_q     <= 1'b1;
          if (complete) begin
            latched_q <= frame_next[BYTE_W +: CH_BITS];
            if (fcnt_q != '1) fcnt_q <= fcnt_q + 1'b1;
          end
        end
        KIND_TICK: begin
          if (gap_q != '1) gap_q <= gap_q + 1'b1;
        end
        KIND_CONVERT: begin
          fcnt_q <= '0;
          if (lost) failsafe_q <= 1'b1;
        end
        KIND_DETECT: begin
          fcnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/sfrs_back.sv =====
// ----------------------------------------------------------------------------
// sfrs_back
// Scaler: walks the channels of a job through a four-stage pipeline.
// ----------------------------------------------------------------------------
module sfrs_back
  import sfrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_avail_i,
  input  job_t             q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output meta_t            out_meta_o,
  output logic [VAL_W-1:0] out_value_o
);

  // job under way
  logic               active_q;
  logic [CH_W-1:0]    ch_q;
  logic [CH_BITS-1:0] raw_q;
  logic               lost_q;
  logic               failsafe_q;

  // pipeline
  logic                     v1_q, v2_q, v3_q, out_valid_q;
  meta_t                    m1_q, m2_q, m3_q, out_meta_q;
  logic signed [PROD_W-1:0] prod1_q;
  logic signed [NUM_W-1:0]  num2_q;
  logic                     neg3_q;
  logic [QUOT_W-1:0]        quot3_q;
  logic [VAL_W-1:0]         out_value_q;

  logic                     en;
  logic                     issue;
  logic                     last_issue;
  meta_t                    m0;
  logic signed [RAW_W:0]    diff;
  logic signed [RAW_W:0]    gain_s;
  logic signed [PROD_W-1:0] prod_d;
  logic [OFFK_W-1:0]        off_k;
  logic signed [NUM_W-1:0]  num_d;
  logic [DPROD_W-1:0]       dprod;
  logic [VAL_W-1:0]         value_d;

  assign en         = !out_valid_q || out_ready_i;
  assign issue      = active_q && en;
  assign last_issue = issue && (ch_q == CH_W'(OUT_CHANNELS - 1));
  assign pop_o      = q_avail_i && (!active_q || last_issue);

  // job sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ch_q     <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      ch_q     <= '0;
    end else if (issue) begin
      ch_q <= ch_q + 1'b1;
      if (last_issue) active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      raw_q      <= q_data_i.raw;
      lost_q     <= q_data_i.lost;
      failsafe_q <= q_data_i.failsafe;
    end else if (issue) begin
      raw_q <= raw_q >> RAW_W;
    end
  end

  // stage 1: subtract center, multiply by gain
  always_comb begin
    m0.channel  = ch_q;
    m0.lost     = lost_q;
    m0.failsafe = failsafe_q;
    m0.last     = (ch_q == CH_W'(OUT_CHANNELS - 1));
    diff        = $signed({1'b0, raw_q[RAW_W-1:0]}) - $signed({1'b0, cfg_i.center});
    gain_s      = $signed({1'b0, cfg_i.gain_milli});
    prod_d      = gain_s * diff;
  end

  // stage 2: add offset in thousandths
  always_comb begin
    off_k = OFFK_W'(cfg_i.output_offset) * OFFK_W'(1000);
    num_d = {prod1_q[PROD_W-1], prod1_q} + $signed({{(NUM_W-OFFK_W){1'b0}}, off_k});
  end

  // stage 3: divide by 1000 through the reciprocal
  assign dprod = DPROD_W'(num2_q[MAG_W-1:0]) * DPROD_W'(DIV_RECIP);

  // output stage: zero a lost result, clamp the rest to the value range
  always_comb begin
    if (m3_q.lost || neg3_q) begin
      value_d = '0;
    end else if (quot3_q > QUOT_W'({VAL_W{1'b1}})) begin
      value_d = '1;
    end else begin
      value_d = quot3_q[VAL_W-1:0];
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q        <= m0;
      prod1_q     <= prod_d;
      m2_q        <= m1_q;
      num2_q      <= num_d;
      m3_q        <= m2_q;
      neg3_q      <= num2_q[NUM_W-1];
      quot3_q     <= dprod[DIV_SHIFT +: QUOT_W];
      out_meta_q  <= m3_q;
      out_value_q <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_meta_o  = out_meta_q;
  assign out_value_o = out_value_q;

endmodule

// ===== hdl/sbus_frame_receiver_scaler.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_receiver_scaler
// SBUS deframer with frame-rate loss detection and channel scaling.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the item kind (byte, microsecond tick, convert,
// detect), tdata the received byte. Bytes and ticks update the frame assembler
// at once; detect clears the frame count; convert queues one job that yields
// ten results, one per channel, tlast on channel 9.
// Output stream: tdata holds the scaled value, tuser the channel index and the
// lost and failsafe flags.
// Throughput: one input transfer per cycle while the two-entry job queue has
// room; a convert job streams its ten results at one per cycle while the output
// is ready, set by the single multiply/divide pipeline of the scaler.
// With the scaler idle, the first result of a convert passes the queue write,
// the job load and the four pipeline stages.
// Reset clears counters, flags, the latched frame and the queue, and loads the
// default register values. A stalled output freezes the scaler pipeline; the
// front keeps taking bytes and ticks until the queue is full. Registers are written
// via cfg_we_i/cfg_idx_i/cfg_data_i by the user only while idle, unenforced by the block.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_scaler
  import sfrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [7:0] data
  input  logic [1:0]            s_axis_tuser_i,   // [1:0] kind
  // output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o,   // [11:0] value, [15:12] zero
  output logic [5:0]            m_axis_tuser_o,   // [3:0] channel, [4] lost, [5] failsafe
  output logic                  m_axis_tlast_o,
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t             cfg_q;
  logic             q_full;
  logic             q_push;
  job_t             q_push_data;
  logic             q_pop;
  logic             q_avail;
  job_t             q_pop_data;
  meta_t            out_meta;
  logic [VAL_W-1:0] out_value;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit     <= 12'd2500;
      cfg_q.min_frames    <= 8'd5;
      cfg_q.gain_milli    <= 11'd644;
      cfg_q.center        <= 11'd1024;
      cfg_q.output_offset <= 12'd1500;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAP_LIMIT:     cfg_q.gap_limit     <= cfg_data_i;
        CFG_MIN_FRAMES:    cfg_q.min_frames    <= cfg_data_i[7:0];
        CFG_GAIN_MILLI:    cfg_q.gain_milli    <= cfg_data_i[10:0];
        CFG_CENTER:        cfg_q.center        <= cfg_data_i[10:0];
        CFG_OUTPUT_OFFSET: cfg_q.output_offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  sfrs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .avail_o     (q_avail),
    .pop_data_o  (q_pop_data)
  );

  sfrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_avail_i   (q_avail),
    .q_data_i    (q_pop_data),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_meta_o  (out_meta),
    .out_value_o (out_value)
  );

  // output packing
  assign m_axis_tdata_o = {4'b0000, out_value};
  assign m_axis_tuser_o = {out_meta.failsafe, out_meta.lost, out_meta.channel};
  assign m_axis_tlast_o = out_meta.last;

  // last result of a job is always the top channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> out_meta.channel == CH_W'(OUT_CHANNELS - 1))
    else $error("tlast on a channel other than the last");

  // a lost result reports zero and carries failsafe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_meta.lost |-> out_value == '0 && out_meta.failsafe)
    else $error("lost result with nonzero value or without failsafe");

  // no job is queued while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  // the scaler only takes a job that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_avail)
    else $error("job popped from an empty queue");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sbus frame receiver and scaler. A short scripted
// sequence covers the extremes and typed results. Random phases follow, with
// different register settings and input and output back-pressure. They mix
// clean frames, converts, detects, tick bursts and noise bytes. Every result
// is checked against an in-bench prediction of the frame assembler and the
// channel scaler.
// ----------------------------------------------------------------------------
module tb_top;
  import sfrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS   = 36;
  localparam int unsigned VAL_MAX       = (1 << VAL_W) - 1;
  // index past the register list, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_e;

  // one line of the opening script: a register write or a repeated item
  typedef struct packed {
    row_e                  op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    kind_e                 kind;
    logic [7:0]            data;
    logic [7:0]            reps;
    logic                  typed;
    logic [VAL_W-1:0]      t_value;
    logic                  t_lost;
    logic                  t_failsafe;
  } step_t;

  // one channel report as seen on the output stream
  typedef struct packed {
    logic [3:0]       pad;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
    logic             lost;
    logic             failsafe;
    logic             last;
  } reading_t;

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  s_valid    = 1'b0;
  logic                  s_ready;
  logic [7:0]            s_tdata    = '0;
  kind_e                 s_kind     = KIND_BYTE;
  logic                  m_valid;
  logic                  m_ready    = 1'b0;
  logic [15:0]           m_tdata;
  logic [5:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // typed expectation riding along with the item being offered
  logic                  item_typed = 1'b0;
  logic [VAL_W-1:0]      item_t_value = '0;
  logic                  item_t_lost = 1'b0;
  logic                  item_t_failsafe = 1'b0;

  // predicted receiver state
  cfg_t model_cfg = '{gap_limit: 12'd2500, min_frames: 8'd5, gain_milli: 11'd644,
                      center: 11'd1024, output_offset: 12'd1500};
  logic [7:0]        asm_bytes  [FRAME_BYTES] = '{default: '0};
  logic [7:0]        held_frame [FRAME_BYTES] = '{default: '0};
  int unsigned       asm_count    = 0;
  logic [GAP_W-1:0]  idle_us      = '0;
  logic              line_active  = 1'b0;
  logic [FCNT_W-1:0] frames_seen  = '0;
  logic              lost_now     = 1'b0;
  logic              failsafe_now = 1'b0;
  reading_t          pending_readings [$];

  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;

  step_t opening_steps [16] = '{
    '{ROW_CFG,  CFG_MIN_FRAMES,    12'd0,    KIND_BYTE,    8'h00, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_CONVERT, 8'hFF, 8'd1,  1'b1, 12'd840,  1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_DETECT,  8'h00, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_BYTE,    HEADER_BYTE, 8'd1, 1'b0, 12'd0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_BYTE,    8'hFF, 8'd24, 1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_TICK,    8'hAA, 8'd2,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_CONVERT, 8'h55, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_CFG,  CFG_GAIN_MILLI,    12'd2047, KIND_BYTE,    8'h00, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_CFG,  CFG_CENTER,        12'd0,    KIND_BYTE,    8'h00, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_CFG,  CFG_OUTPUT_OFFSET, 12'd4095, KIND_BYTE,    8'h00, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_CONVERT, 8'h00, 8'd1,  1'b1, 12'd4095, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_BYTE,    8'h00, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_DETECT,  8'hFF, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_CFG,  CFG_MIN_FRAMES,    12'd255,  KIND_BYTE,    8'h00, 8'd1,  1'b0, 12'd0,    1'b0, 1'b0},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_CONVERT, 8'hFF, 8'd1,  1'b1, 12'd0,    1'b1, 1'b1},
    '{ROW_ITEM, CFG_GAP_LIMIT,     12'd0,    KIND_BYTE,    HEADER_BYTE, 8'd1, 1'b0, 12'd0, 1'b0, 1'b0}
  };

  sbus_frame_receiver_scaler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // scaled pulse width of one raw channel, clamped to the output range
  function automatic logic [VAL_W-1:0] scale_reading(input logic [RAW_W-1:0] raw);
    longint num;
    num = longint'(model_cfg.gain_milli) * (longint'(raw) - longint'(model_cfg.center))
        + longint'(model_cfg.output_offset) * 1000;
    if (num < 0) return '0;
    if (num / 1000 > longint'(VAL_MAX)) return VAL_MAX[VAL_W-1:0];
    return VAL_W'(num / 1000);
  endfunction

  // advance the predicted receiver by one accepted item, queue its reports
  task automatic absorb_item(input kind_e kind, input logic [7:0] data);
    logic [8*FRAME_BYTES-1:0] flat;
    reading_t r;
    case (kind)
      KIND_BYTE: begin
        if (line_active && idle_us > model_cfg.gap_limit) asm_count = 0;
        idle_us = '0;
        line_active = 1'b1;
        if (data == HEADER_BYTE || asm_count >= FRAME_BYTES) asm_count = 0;
        asm_bytes[asm_count] = data;
        asm_count++;
        if (asm_count == FRAME_BYTES) begin
          held_frame = asm_bytes;
          if (frames_seen != '1) frames_seen++;
        end
      end
      KIND_TICK: begin
        if (idle_us != '1) idle_us++;
      end
      default: begin
        lost_now = frames_seen < model_cfg.min_frames;
        frames_seen = '0;
        if (kind == KIND_CONVERT) begin
          if (lost_now) failsafe_now = 1'b1;
          for (int b = 0; b < FRAME_BYTES; b++) flat[8*b +: 8] = held_frame[b];
          // channels are packed 11 bits each, little endian, from frame byte 1
          for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
            r.pad      = '0;
            r.channel  = CH_W'(ch);
            r.value    = lost_now ? '0 : scale_reading(flat[8 + RAW_W*ch +: RAW_W]);
            r.lost     = lost_now;
            r.failsafe = failsafe_now;
            r.last     = (ch == OUT_CHANNELS - 1);
            if (item_typed) begin
              r.value    = item_t_value;
              r.lost     = item_t_lost;
              r.failsafe = item_t_failsafe;
            end
            pending_readings.push_back(r);
          end
        end
      end
    endcase
  endtask

  // register writes and input transfers feed the prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAP_LIMIT:     model_cfg.gap_limit     = cfg_data[GAP_W-1:0];
          CFG_MIN_FRAMES:    model_cfg.min_frames    = cfg_data[FCNT_W-1:0];
          CFG_GAIN_MILLI:    model_cfg.gain_milli    = cfg_data[RAW_W-1:0];
          CFG_CENTER:        model_cfg.center        = cfg_data[RAW_W-1:0];
          CFG_OUTPUT_OFFSET: model_cfg.output_offset = cfg_data[VAL_W-1:0];
          default: ;
        endcase
      end
      if (s_valid && s_ready) absorb_item(s_kind, s_tdata);
    end
  end

  // output transfers against the oldest prediction, random back-pressure
  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = {m_tdata[15:12], m_tuser[3:0], m_tdata[11:0], m_tuser[4], m_tuser[5], m_tlast};
      if (pending_readings.size() == 0) begin
        $display("%0t unexpected result: ch %0d value %0d lost %0b failsafe %0b last %0b",
                 $time, got.channel, got.value, got.lost, got.failsafe, got.last);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected ch %0d value %0d lost %0b failsafe %0b last %0b pad %0h",
                   $time, want.channel, want.value, want.lost, want.failsafe, want.last, want.pad);
          $display("%0t           actual   ch %0d value %0d lost %0b failsafe %0b last %0b pad %0h",
                   $time, got.channel, got.value, got.lost, got.failsafe, got.last, got.pad);
          errors++;
        end
      end
    end
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // offer one item after a random gap, return once it is transferred
  task automatic push_item(input kind_e kind, input logic [7:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_kind  <= kind;
    s_tdata <= data;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == HEADER_BYTE) ? ~b : b;
  endfunction

  // stop offering, wait for every predicted result and let the pipe empty
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [11:0] gap, input logic [7:0] minf,
                            input logic [10:0] gain, input logic [10:0] mid,
                            input logic [11:0] offs);
    settle();
    write_reg(CFG_GAP_LIMIT, gap);
    write_reg(CFG_MIN_FRAMES, 12'(minf));
    write_reg(CFG_GAIN_MILLI, 12'(gain));
    write_reg(CFG_CENTER, 12'(mid));
    write_reg(CFG_OUTPUT_OFFSET, offs);
  endtask

  // header plus payload, optionally with short tick bursts between bytes
  task automatic send_frame(input bit jitter);
    push_item(KIND_BYTE, HEADER_BYTE);
    repeat (FRAME_BYTES - 1) begin
      if (jitter && $urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) push_item(KIND_TICK, 8'($urandom));
      push_item(KIND_BYTE, payload_byte());
    end
  endtask

  // mostly clean frames and events, some line noise and long gaps
  task automatic run_random(input int unsigned budget);
    int unsigned stop;
    int unsigned pick;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 50) send_frame(1'b1);
      else if (pick < 68) push_item(KIND_CONVERT, 8'($urandom));
      else if (pick < 74) push_item(KIND_DETECT, 8'($urandom));
      else if (pick < 86) repeat ($urandom_range(1, 6)) push_item(KIND_TICK, 8'($urandom));
      else repeat ($urandom_range(1, 6)) push_item(KIND_BYTE, 8'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening script
    foreach (opening_steps[i]) begin
      if (opening_steps[i].op == ROW_CFG) begin
        settle();
        write_reg(opening_steps[i].idx, opening_steps[i].wdata);
      end else begin
        item_typed      <= opening_steps[i].typed;
        item_t_value    <= opening_steps[i].t_value;
        item_t_lost     <= opening_steps[i].t_lost;
        item_t_failsafe <= opening_steps[i].t_failsafe;
        repeat (opening_steps[i].reps)
          push_item(opening_steps[i].kind, opening_steps[i].data);
      end
    end

    // random phases under different settings and back-pressure
    set_config(12'd3, 8'd1, 11'd644, 11'd1024, 12'd1500);
    idle_pct = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS);

    set_config(12'd1, 8'd0, 11'd2047, 11'd0, 12'd0);
    idle_pct = 72;
    stall_pct = 0;
    run_random(PHASE_ITEMS);

    set_config(12'd4094, 8'd2, 11'd0, 11'd2047, 12'd4095);
    idle_pct = 0;
    stall_pct = 72;
    run_random(PHASE_ITEMS);

    set_config(12'($urandom_range(1, 20)), 8'($urandom_range(0, 2)), 11'($urandom),
               11'($urandom), 12'($urandom));
    write_reg(CFG_SPARE_IDX, 12'($urandom));
    idle_pct = 31;
    stall_pct = 31;
    run_random(PHASE_ITEMS);

    set_config(12'($urandom_range(1, 20)), 8'($urandom_range(0, 2)), 11'($urandom),
               11'($urandom), 12'($urandom));
    idle_pct = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS);

    settle();
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
